### hw/rtl/tasps_pkg.sv
// ----------------------------------------------------------------------------
// tasps_pkg
// Shared types, constants and the half-step coil table for the three-axis
// stepper pulse sequencer.
// ----------------------------------------------------------------------------
package tasps_pkg;

  localparam int unsigned MOTOR_COUNT_DEF = 3;
  localparam int unsigned IO_MOTORS       = 3;

  localparam logic [15:0] RESET_PERIOD = 16'd4000;
  localparam logic [15:0] RESET_COUNT  = 16'd1;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] speed_one;
    logic signed [15:0] speed_two;
    logic signed [15:0] speed_three;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coils_one;
    logic [3:0] coils_two;
    logic [3:0] coils_three;
    logic       stepped_one;
    logic       stepped_two;
    logic       stepped_three;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic load;
  } motor_ctl_t;

  function automatic logic [3:0] coil_pattern(input logic [2:0] ph);
    logic [3:0] pat;
    case (ph)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      3'd7:    pat = 4'h9;
      default: pat = 4'h0;
    endcase
    return pat;
  endfunction

endpackage

### hw/rtl/tasps_motor.sv
// ----------------------------------------------------------------------------
// tasps_motor
// One motor channel: countdown, period, direction, phase and latched coil
// pattern; steps when the countdown reaches zero on a tick.
// ----------------------------------------------------------------------------
module tasps_motor
  import tasps_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  motor_ctl_t         ctl,
  input  logic signed [15:0] speed,
  output logic [3:0]         coils_nxt,
  output logic               stepped
);

  logic [15:0] countdown_r, countdown_nxt;
  logic [15:0] period_r, period_nxt;
  logic        fwd_r, fwd_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  coils_r;
  logic [15:0] dec;
  logic [15:0] speed_u;

  assign dec     = countdown_r - 16'd1;
  assign speed_u = speed;
  assign stepped = ctl.tick && (dec == 16'd0);

  always_comb begin
    countdown_nxt = countdown_r;
    period_nxt    = period_r;
    fwd_nxt       = fwd_r;
    phase_nxt     = phase_r;
    coils_nxt     = coils_r;
    if (ctl.load) begin
      if (speed_u != 16'd0 && !speed_u[15]) begin
        fwd_nxt    = 1'b1;
        period_nxt = speed_u;
      end else begin
        fwd_nxt    = 1'b0;
        period_nxt = 16'd0 - speed_u;
      end
    end else if (ctl.tick) begin
      countdown_nxt = dec;
      if (dec == 16'd0) begin
        coils_nxt     = coil_pattern(phase_r);
        phase_nxt     = fwd_r ? phase_r + 3'd1 : phase_r - 3'd1;
        countdown_nxt = period_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= RESET_COUNT;
      period_r    <= RESET_PERIOD;
      fwd_r       <= 1'b0;
      phase_r     <= 3'd0;
      coils_r     <= 4'd0;
    end else begin
      countdown_r <= countdown_nxt;
      period_r    <= period_nxt;
      fwd_r       <= fwd_nxt;
      phase_r     <= phase_nxt;
      coils_r     <= coils_nxt;
    end
  end

endmodule

### hw/rtl/three_axis_stepper_pulse_sequencer_unit.sv
// ----------------------------------------------------------------------------
// three_axis_stepper_pulse_sequencer_unit
// Half-step coil sequencer for MOTOR_COUNT stepper motors, three reported.
//
// Input beats (in_valid/in_ready, in_data) carry either a timer tick or a
// load of three signed speeds. Every input beat yields exactly one output
// beat (out_valid/out_ready, out_data) with the latched coil patterns and
// per-motor step flags. A beat passes an input register, then the motor
// update logic, and lands in the output register. One beat per cycle is
// sustained while the receiver keeps out_ready high; the motor state update
// is a single decrement-compare per motor between those two registers.
// When the receiver stalls, the output register holds its beat and the
// input register takes one more; in_ready then drops until the output
// drains. Reset empties both registers and returns every motor to
// countdown 1, period 4000, backward, phase 0, coils 0.
// ----------------------------------------------------------------------------
module three_axis_stepper_pulse_sequencer_unit
  import tasps_pkg::*;
#(
  parameter int unsigned MOTOR_COUNT = MOTOR_COUNT_DEF
)(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic      advance;
  motor_ctl_t ctl;

  logic signed [15:0] speed_io [IO_MOTORS];
  logic [3:0]         coils    [MOTOR_COUNT];
  logic               stepped  [MOTOR_COUNT];
  logic [3:0]         coils_io   [IO_MOTORS];
  logic               stepped_io [IO_MOTORS];

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign ctl.tick = advance && (in_r.cmd == CMD_TICK);
  assign ctl.load = advance && (in_r.cmd == CMD_LOAD);

  assign speed_io[0] = in_r.speed_one;
  assign speed_io[1] = in_r.speed_two;
  assign speed_io[2] = in_r.speed_three;

  for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_motor
    motor_ctl_t         mctl;
    logic signed [15:0] mspeed;
    if (m < IO_MOTORS) begin : g_io
      assign mctl   = ctl;
      assign mspeed = speed_io[m];
    end else begin : g_hidden
      assign mctl.tick = ctl.tick;
      assign mctl.load = 1'b0;
      assign mspeed    = 16'sd0;
    end
    tasps_motor u_motor (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (mctl),
      .speed     (mspeed),
      .coils_nxt (coils[m]),
      .stepped   (stepped[m])
    );
  end

  for (genvar m = 0; m < IO_MOTORS; m++) begin : g_report
    if (m < MOTOR_COUNT) begin : g_on
      assign coils_io[m]   = coils[m];
      assign stepped_io[m] = stepped[m];
    end else begin : g_off
      assign coils_io[m]   = 4'd0;
      assign stepped_io[m] = 1'b0;
    end
  end

  always_comb begin
    out_nxt.coils_one     = coils_io[0];
    out_nxt.coils_two     = coils_io[1];
    out_nxt.coils_three   = coils_io[2];
    out_nxt.stepped_one   = stepped_io[0];
    out_nxt.stepped_two   = stepped_io[1];
    out_nxt.stepped_three = stepped_io[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
